// File: design/flrb_pkg.sv
// Shared types and constants for the frame locator ring buffer.
// No dependencies; used by frame_locator_ring_buffer_unit.
package flrb_pkg;

   // Store depth; a power of two so that indices wrap by truncation.
   localparam int unsigned DEPTH = 256;
   localparam int unsigned ADDR_W = $clog2(DEPTH);

   typedef logic [ADDR_W-1:0] addr_type;

   localparam logic [7:0] FRAME_DELIM = 8'h7E;
   localparam addr_type LAST_ADDR = addr_type'(DEPTH - 1);

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_FIND = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_HI,
      ST_LO,
      ST_TYPE,
      ST_READ,
      ST_SEND
   } state_type;

endpackage

// File: design/frame_locator_ring_buffer_unit.sv
// Frame locator ring buffer: byte store, scan sequencer and result register.
// Depends on flrb_pkg.
//
// Usage:
//   req_* channel carries one transaction per command: push a received byte
//   (req_opcode push, req_rx_byte), find a frame (find) or read a payload byte
//   at payload start plus req_offset (read). Opcode 3 is taken and dropped.
//   rsp_* channel returns one transaction per find or read; push gives none.
//   A transaction moves at a clock edge with valid high and stall low.
// Sequencing:
//   push: done in the idle state, next request taken in the following cycle.
//   read: passes through the read and send states into the output register.
//   find: the single read port of the store is walked one entry per cycle,
//     with a registered read. A delimiter at index k is cleared, then the
//     length and type bytes are read in the hi, lo and type states before
//     the send state; with no delimiter the scan ends at the last entry.
//   req_stall is high while a command is in progress.
// Reset (synchronous, active high): pointers and length go to zero, then a
//   clearing pass writes zero to every store entry, one per cycle; req_stall
//   stays high during that pass.
// Backpressure: a result waits in the output register while rsp_stall is high;
//   a new request is still accepted, and a following result waits in the send
//   state until the output register frees up.
module frame_locator_ring_buffer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [7:0]  rsp_frame_type,
   output logic [15:0] rsp_frame_len,
   output logic [7:0]  rsp_data_byte
);

   // byte store, one write and one registered read port
   logic [7:0] mem [flrb_pkg::DEPTH];
   logic [7:0] rd_data_ff;

   flrb_pkg::state_type state_ff, state_in;
   flrb_pkg::addr_type  wp_ff, wp_in;          // write pointer
   flrb_pkg::addr_type  start_ff, start_in;    // payload start
   logic [15:0]         len_ff, len_in;        // frame length
   flrb_pkg::addr_type  ptr_ff, ptr_in;        // scan / clear issue pointer
   flrb_pkg::addr_type  chk_ptr_ff, chk_ptr_in; // index of rd_data_ff during scan
   logic                chk_vld_ff, chk_vld_in;
   flrb_pkg::addr_type  base_ff, base_in;      // delimiter index
   logic [7:0]          hi_ff, hi_in;

   // pending result
   logic        res_found_ff, res_found_in;
   logic [7:0]  res_type_ff, res_type_in;
   logic [15:0] res_len_ff, res_len_in;
   logic [7:0]  res_data_ff, res_data_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [7:0]  rsp_type_ff, rsp_type_in;
   logic [15:0] rsp_len_ff, rsp_len_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   logic               mem_wr_en;
   flrb_pkg::addr_type mem_wr_addr;
   logic [7:0]         mem_wr_data;
   flrb_pkg::addr_type rd_addr;
   logic               req_take;
   logic               rsp_load;
   logic               scan_hit;

   assign req_stall      = (state_ff != flrb_pkg::ST_IDLE);
   assign req_take       = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_frame_type = rsp_type_ff;
   assign rsp_frame_len  = rsp_len_ff;
   assign rsp_data_byte  = rsp_data_ff;

   assign scan_hit = chk_vld_ff && (rd_data_ff == flrb_pkg::FRAME_DELIM);

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      chk_ptr_in   = chk_ptr_ff;
      chk_vld_in   = 1'b0;
      base_in      = base_ff;
      hi_in        = hi_ff;
      res_found_in = res_found_ff;
      res_type_in  = res_type_ff;
      res_len_in   = res_len_ff;
      res_data_in  = res_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ptr_ff;
      mem_wr_data  = 8'd0;
      rd_addr      = ptr_ff;
      rsp_load     = 1'b0;

      case (state_ff)
         flrb_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff;
            ptr_in      = flrb_pkg::addr_type'(ptr_ff + 1'b1);
            if (ptr_ff == flrb_pkg::LAST_ADDR) begin
               state_in = flrb_pkg::ST_IDLE;
            end
         end
         flrb_pkg::ST_IDLE: begin
            rd_addr = flrb_pkg::addr_type'(start_ff + flrb_pkg::addr_type'(req_offset));
            if (req_take) begin
               case (req_opcode)
                  flrb_pkg::OP_PUSH: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = wp_ff;
                     mem_wr_data = req_rx_byte;
                     wp_in       = flrb_pkg::addr_type'(wp_ff + 1'b1);
                  end
                  flrb_pkg::OP_FIND: begin
                     ptr_in   = '0;
                     state_in = flrb_pkg::ST_SCAN;
                  end
                  flrb_pkg::OP_READ: begin
                     state_in = flrb_pkg::ST_READ;
                  end
                  default: begin
                     state_in = flrb_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         flrb_pkg::ST_SCAN: begin
            // issue ptr_ff, check the entry issued in the previous cycle
            rd_addr    = ptr_ff;
            ptr_in     = flrb_pkg::addr_type'(ptr_ff + 1'b1);
            chk_ptr_in = ptr_ff;
            chk_vld_in = 1'b1;
            if (scan_hit) begin
               // clear the delimiter; entry k+1 is already in flight
               mem_wr_en   = 1'b1;
               mem_wr_addr = chk_ptr_ff;
               base_in     = chk_ptr_ff;
               state_in    = flrb_pkg::ST_HI;
            end else if (chk_vld_ff && chk_ptr_ff == flrb_pkg::LAST_ADDR) begin
               res_found_in = 1'b0;
               res_type_in  = 8'd0;
               res_len_in   = len_ff;
               res_data_in  = 8'd0;
               state_in     = flrb_pkg::ST_SEND;
            end
         end
         flrb_pkg::ST_HI: begin
            hi_in    = rd_data_ff;
            rd_addr  = flrb_pkg::addr_type'(base_ff + flrb_pkg::addr_type'(2));
            state_in = flrb_pkg::ST_LO;
         end
         flrb_pkg::ST_LO: begin
            len_in   = {hi_ff, rd_data_ff};
            start_in = flrb_pkg::addr_type'(base_ff + flrb_pkg::addr_type'(3));
            rd_addr  = flrb_pkg::addr_type'(base_ff + flrb_pkg::addr_type'(3));
            state_in = flrb_pkg::ST_TYPE;
         end
         flrb_pkg::ST_TYPE: begin
            res_found_in = 1'b1;
            res_type_in  = rd_data_ff;
            res_len_in   = len_ff;
            res_data_in  = 8'd0;
            state_in     = flrb_pkg::ST_SEND;
         end
         flrb_pkg::ST_READ: begin
            res_found_in = 1'b0;
            res_type_in  = 8'd0;
            res_len_in   = 16'd0;
            res_data_in  = rd_data_ff;
            state_in     = flrb_pkg::ST_SEND;
         end
         flrb_pkg::ST_SEND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = flrb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = flrb_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_type_in  = rsp_type_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res_found_ff;
         rsp_type_in  = res_type_ff;
         rsp_len_in   = res_len_ff;
         rsp_data_in  = res_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flrb_pkg::ST_CLEAR;
         wp_ff        <= '0;
         start_ff     <= '0;
         len_ff       <= 16'd0;
         ptr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         start_ff     <= start_in;
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ptr_ff   <= chk_ptr_in;
      base_ff      <= base_in;
      hi_ff        <= hi_in;
      res_found_ff <= res_found_in;
      res_type_ff  <= res_type_in;
      res_len_ff   <= res_len_in;
      res_data_ff  <= res_data_in;
      rsp_found_ff <= rsp_found_in;
      rsp_type_ff  <= rsp_type_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // store
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

`ifndef SYNTHESIS
   // a new result only comes out of the send state
   assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) || !$past(rsp_stall)) && rsp_valid_ff
         |-> $past(state_ff) == flrb_pkg::ST_SEND)
      else $error("result appeared outside send state");

   // successful find results never carry a data byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_data_ff == 8'd0)
      else $error("found result with nonzero data byte");

   // a push advances the write pointer by exactly one
   assert property (@(posedge clock) disable iff (reset)
      req_take && req_opcode == flrb_pkg::OP_PUSH
         |=> wp_ff == flrb_pkg::addr_type'($past(wp_ff) + 1'b1))
      else $error("write pointer did not advance on push");

   // the scan ends once the last entry has been checked
   assert property (@(posedge clock) disable iff (reset)
      state_ff == flrb_pkg::ST_SCAN && chk_vld_ff && chk_ptr_ff == flrb_pkg::LAST_ADDR
         |=> state_ff != flrb_pkg::ST_SCAN)
      else $error("scan ran past the last entry");
`endif

endmodule

// File: dv/tb_frame_locator_ring_buffer_unit.sv
// Self-checking testbench for frame_locator_ring_buffer_unit: push, find and read
// transactions checked against an in-bench mirror of the ring store.
// Depends on flrb_pkg and the RTL top module.
`timescale 1ns / 100ps

module tb_frame_locator_ring_buffer_unit;

   // Opcode 3 is not decoded by the block; it is taken and dropped.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned ITEM_TARGET = 1450;
   localparam int unsigned HOLD_CYCLES = 600;
   localparam int unsigned CYCLE_LIMIT = 2500000;
   // A find with no delimiter scans the whole store; leave margin at the end.
   localparam int unsigned TAIL_CYCLES = flrb_pkg::DEPTH + 40;

   typedef struct packed {
      logic        found;
      logic [7:0]  frame_type;
      logic [15:0] frame_len;
      logic [7:0]  data_byte;
   } frame_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [7:0]  req_rx_byte;
   logic [7:0]  req_offset;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [7:0]  rsp_frame_type;
   logic [15:0] rsp_frame_len;
   logic [7:0]  rsp_data_byte;

   // Mirror of the block state, updated as each transaction is accepted.
   logic [7:0]         mirror_store [flrb_pkg::DEPTH];
   flrb_pkg::addr_type mirror_wr_ptr;
   flrb_pkg::addr_type mirror_start;
   logic [15:0]        mirror_length;
   bit                 last_find_hit;

   frame_result_type pending_results[$];
   frame_result_type head_result;
   int unsigned      mismatches = 0;
   int unsigned      items_taken = 0;
   int unsigned      cycle_count = 0;

   // Knobs set by the stimulus process, plus the result side's hold and stall counters.
   logic        gaps_on = 1'b1;
   logic        stalls_on = 1'b1;
   logic        hold_trigger = 1'b0;
   logic        hold_seen = 1'b0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   int unsigned free_left = 0;

   frame_locator_ring_buffer_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_rx_byte    (req_rx_byte),
      .req_offset     (req_offset),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_frame_type (rsp_frame_type),
      .rsp_frame_len  (rsp_frame_len),
      .rsp_data_byte  (rsp_data_byte)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hang guard: a run that never drains ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   //--------------------------------------------------------------------------
   // Frame locator mirror. Push writes at the write pointer; find scans from
   // index 0 for the first delimiter, clears it and latches length and start;
   // read returns the byte at start plus offset. Indices wrap by truncation.
   //--------------------------------------------------------------------------
   function automatic void apply_command(input logic [1:0] op, input logic [7:0] rx,
                                         input logic [7:0] off, output bit produces,
                                         output frame_result_type res);
      int k;
      bit hit;
      logic [7:0] len_hi;
      logic [7:0] len_lo;
      res = '0;
      produces = 1'b0;
      hit = 1'b0;
      case (op)
         flrb_pkg::OP_PUSH: begin
            mirror_store[mirror_wr_ptr] = rx;
            mirror_wr_ptr = mirror_wr_ptr + 1'b1;
         end
         flrb_pkg::OP_FIND: begin
            produces = 1'b1;
            for (k = 0; k < flrb_pkg::DEPTH && !hit; k++) begin
               if (mirror_store[k] == flrb_pkg::FRAME_DELIM) begin
                  hit = 1'b1;
                  mirror_store[k] = 8'h00;
                  len_hi = mirror_store[flrb_pkg::addr_type'(k + 1)];
                  len_lo = mirror_store[flrb_pkg::addr_type'(k + 2)];
                  mirror_start = flrb_pkg::addr_type'(k + 3);
                  mirror_length = {len_hi, len_lo};
                  res.found = 1'b1;
                  res.frame_type = mirror_store[mirror_start];
               end
            end
            // Miss: length reports the last latched value, nothing changes.
            res.frame_len = mirror_length;
            last_find_hit = hit;
         end
         flrb_pkg::OP_READ: begin
            produces = 1'b1;
            res.data_byte = mirror_store[flrb_pkg::addr_type'(mirror_start + off)];
         end
         default: ;
      endcase
   endfunction

   //--------------------------------------------------------------------------
   // Result side: random stall pattern plus one long hold-off on request.
   //--------------------------------------------------------------------------
   function automatic int unsigned pick_stall();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   always @(posedge clock) begin
      if (hold_trigger && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (free_left != 0) begin
         free_left <= free_left - 1;
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_trigger) hold_seen <= 1'b0;
         rsp_stall <= 1'b0;
         free_left <= $urandom_range(0, 12);
         stall_left <= stalls_on ? pick_stall() : 0;
      end
   end

   // Result checker: each accepted result against the oldest expectation.
   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display({"%0t: unexpected result: expected none, ",
                      "actual found %0h type %0h len %0h data %0h"},
                     $time, rsp_found, rsp_frame_type, rsp_frame_len, rsp_data_byte);
            mismatches++;
         end else begin
            head_result = pending_results.pop_front();
            check_field("found", head_result.found, rsp_found);
            check_field("frame_type", head_result.frame_type, rsp_frame_type);
            check_field("frame_len", head_result.frame_len, rsp_frame_len);
            check_field("data_byte", head_result.data_byte, rsp_data_byte);
         end
      end
   end

   //--------------------------------------------------------------------------
   // Request side.
   //--------------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // One transaction: optional idle gap, offer, wait for the handshake, then
   // update the mirror. Valid is only lowered ahead of a nonzero idle gap,
   // so it never drops and rises within one step.
   task automatic send_item(input logic [1:0] op, input logic [7:0] rx,
                            input logic [7:0] off);
      int unsigned gap;
      bit produces;
      frame_result_type res;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_rx_byte <= rx;
      req_offset <= off;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_command(op, rx, off, produces, res);
      if (produces) pending_results.push_back(res);
      if (op != OP_UNUSED) items_taken++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Finds until the store holds no delimiter (bounded).
   task automatic drain_delimiters();
      int unsigned tries;
      tries = 0;
      last_find_hit = 1'b1;
      while (last_find_hit && tries < 12) begin
         send_item(flrb_pkg::OP_FIND, 8'($urandom), 8'($urandom));
         tries++;
      end
   endtask

   //--------------------------------------------------------------------------
   // Tests.
   //--------------------------------------------------------------------------

   // Cleared store: find misses with zero length; reads see zeros; opcode 3
   // is dropped with no result.
   task automatic test_empty_store();
      send_item(flrb_pkg::OP_FIND, 8'h00, 8'h00);
      send_item(flrb_pkg::OP_READ, 8'h00, 8'h00);
      send_item(flrb_pkg::OP_READ, 8'hFF, 8'hFF);
      send_item(OP_UNUSED, 8'hFF, 8'hFF);
   endtask

   // A well-formed frame, reads around the payload start (large offset wraps
   // back onto the length bytes), a repeated find that misses and keeps the
   // latched length, and a frame carrying the largest length.
   task automatic test_directed_frames();
      send_item(flrb_pkg::OP_PUSH, flrb_pkg::FRAME_DELIM, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'h12, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'h34, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'hC5, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'h00, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'hFF, 8'h00);
      send_item(flrb_pkg::OP_FIND, 8'h00, 8'h00);
      send_item(flrb_pkg::OP_READ, 8'h00, 8'h00);
      send_item(flrb_pkg::OP_READ, 8'h00, 8'h01);
      send_item(flrb_pkg::OP_READ, 8'h00, 8'hFF);
      send_item(flrb_pkg::OP_FIND, 8'h00, 8'h00);
      send_item(flrb_pkg::OP_PUSH, flrb_pkg::FRAME_DELIM, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'hFF, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'hFF, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'h00, 8'h00);
      send_item(flrb_pkg::OP_FIND, 8'h00, 8'h00);
      wait_idle();
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so
   // both result slots fill and the block stalls its input.
   task automatic test_backpressure();
      int unsigned i;
      hold_trigger <= 1'b1;
      send_item(flrb_pkg::OP_PUSH, flrb_pkg::FRAME_DELIM, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'h00, 8'h00);
      send_item(flrb_pkg::OP_PUSH, 8'h04, 8'h00);
      send_item(flrb_pkg::OP_FIND, 8'h00, 8'h00);
      for (i = 0; i < 20; i++)
         send_item(flrb_pkg::OP_READ, 8'($urandom), 8'($urandom_range(0, 6)));
      hold_trigger <= 1'b0;
      wait_idle();
   endtask

   // Delimiter in the second-to-last entry: the low length byte and the type byte
   // wrap around the end of the store.
   task automatic test_wrap_delimiter();
      logic [7:0] fill;
      drain_delimiters();
      while (mirror_wr_ptr != flrb_pkg::LAST_ADDR - 1'b1) begin
         do fill = 8'($urandom_range(0, 255)); while (fill == flrb_pkg::FRAME_DELIM);
         send_item(flrb_pkg::OP_PUSH, fill, 8'($urandom));
      end
      send_item(flrb_pkg::OP_PUSH, flrb_pkg::FRAME_DELIM, 8'($urandom));
      send_item(flrb_pkg::OP_PUSH, 8'($urandom), 8'($urandom));
      send_item(flrb_pkg::OP_PUSH, 8'($urandom), 8'($urandom));
      send_item(flrb_pkg::OP_PUSH, 8'($urandom), 8'($urandom));
      send_item(flrb_pkg::OP_FIND, 8'($urandom), 8'($urandom));
      send_item(flrb_pkg::OP_READ, 8'($urandom), 8'hFF);
      send_item(flrb_pkg::OP_READ, 8'($urandom), 8'hFE);
      send_item(flrb_pkg::OP_READ, 8'($urandom), 8'h00);
   endtask

   // Mostly well-formed frames with random content, then finds and reads into
   // them; else broken frames, noise, lone reads or pushes, drains and pauses.
   task automatic test_random_traffic();
      int unsigned pick;
      int unsigned body;
      logic [7:0] len_hi;
      logic [7:0] len_lo;
      while (items_taken < ITEM_TARGET) begin
         if ($urandom_range(0, 15) == 0) gaps_on <= ~gaps_on;
         if ($urandom_range(0, 15) == 0) stalls_on <= ~stalls_on;
         pick = $urandom_range(0, 19);
         case (pick)
            11, 12: begin
               // Truncated frame: delimiter with at most two following bytes.
               send_item(flrb_pkg::OP_PUSH, flrb_pkg::FRAME_DELIM, 8'($urandom));
               repeat ($urandom_range(0, 2))
                  send_item(flrb_pkg::OP_PUSH, 8'($urandom), 8'($urandom));
               send_item(flrb_pkg::OP_FIND, 8'($urandom), 8'($urandom));
            end
            13, 14: repeat ($urandom_range(1, 6))
               send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            15: drain_delimiters();
            16, 17: repeat ($urandom_range(1, 5))
               send_item(flrb_pkg::OP_READ, 8'($urandom), 8'($urandom));
            18: wait_idle();
            19: send_item(flrb_pkg::OP_PUSH, 8'($urandom), 8'($urandom));
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  len_hi = 8'($urandom);
                  len_lo = 8'($urandom);
               end else begin
                  len_hi = 8'h00;
                  len_lo = 8'($urandom_range(0, 12));
               end
               body = $urandom_range(0, 8);
               send_item(flrb_pkg::OP_PUSH, flrb_pkg::FRAME_DELIM, 8'($urandom));
               send_item(flrb_pkg::OP_PUSH, len_hi, 8'($urandom));
               send_item(flrb_pkg::OP_PUSH, len_lo, 8'($urandom));
               send_item(flrb_pkg::OP_PUSH, 8'($urandom), 8'($urandom));
               repeat (body) send_item(flrb_pkg::OP_PUSH, 8'($urandom), 8'($urandom));
               if ($urandom_range(0, 4) != 0)
                  send_item(flrb_pkg::OP_FIND, 8'($urandom), 8'($urandom));
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(0, 3) == 0)
                     send_item(flrb_pkg::OP_READ, 8'($urandom), 8'($urandom));
                  else
                     send_item(flrb_pkg::OP_READ, 8'($urandom),
                               8'($urandom_range(0, body + 1)));
               end
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = flrb_pkg::OP_PUSH;
      req_rx_byte = 8'h00;
      req_offset = 8'h00;
      mirror_wr_ptr = '0;
      mirror_start = '0;
      mirror_length = '0;
      last_find_hit = 1'b0;
      for (int k = 0; k < flrb_pkg::DEPTH; k++) mirror_store[k] = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_directed_frames();
      test_backpressure();
      test_wrap_delimiter();
      test_random_traffic();

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
